// File: hw/rtl/hllra_pkg.sv
// Shared types and constants for the HyperLogLog register array.
// Holds request codes and the fixed widths of the request and result words.
// No dependencies.
`default_nettype none

package hllra_pkg;

	localparam int REQ_W   = 3;
	localparam int INDEX_W = 14;
	localparam int VALUE_W = 8;
	localparam int ZERO_W  = 15;
	localparam int SUM_W   = 55;
	localparam int PREC_W  = 4;

	typedef logic [REQ_W-1:0]   req_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [ZERO_W-1:0]  zero_t;
	typedef logic [SUM_W-1:0]   sum_t;
	typedef logic [PREC_W-1:0]  prec_t;

	localparam req_t REQ_MAX_UPDATE = 3'd0;
	localparam req_t REQ_OVERWRITE  = 3'd1;
	localparam req_t REQ_READ       = 3'd2;
	localparam req_t REQ_QUERY      = 3'd3;
	localparam req_t REQ_CLEAR      = 3'd4;

	localparam prec_t PREC_RESET = 4'd14;

endpackage

`default_nettype wire

// File: hw/rtl/hll_register_array_unit.sv
// Top level of the HyperLogLog register array: rank store, request sequencer
// and the shared accumulate unit for queries. Depends on hllra_pkg.
//
// Channel  | Direction | Handshake              | Word
// request  | in        | start, accepted !busy  | req_type, index, value
// result   | out       | done strobe, one cycle | read_value, zero_tally,
//          |           |                        | inverse_power_sum, index_error
// config   | in        | cfg_wr_en              | cfg_wr_data (active_precision)
//
// Indexed requests and unused request codes pass through S_IDX: the store read is
// registered on acceptance and any update is written back in S_IDX.
// A query makes one store read per active entry, summed by one shared shift and
// add unit. A clear sweeps every entry of the store.
// After reset the store is swept to zero with busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module hll_register_array_unit #(
	parameter int MAX_PRECISION = 14,
	parameter int SUM_FRAC_BITS = 40
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	input  wire hllra_pkg::req_t   req_type,
	input  wire hllra_pkg::index_t index,
	input  wire hllra_pkg::value_t value,
	input  wire                  cfg_wr_en,
	input  wire hllra_pkg::prec_t  cfg_wr_data,
	output logic                 done,
	output hllra_pkg::value_t    read_value,
	output hllra_pkg::zero_t     zero_tally,
	output hllra_pkg::sum_t      inverse_power_sum,
	output logic                 index_error
);
	import hllra_pkg::*;

	localparam int AW    = MAX_PRECISION;
	localparam int CNTW  = MAX_PRECISION + 1;
	localparam int DEPTH = 1 << MAX_PRECISION;
	localparam int SHW   = 6;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_IDX   = 3'd1;
	localparam logic [2:0] S_QUERY = 3'd2;
	localparam logic [2:0] S_CLEAR = 3'd3;

	logic [2:0]       state_q;
	prec_t            prec_q;
	logic [AW-1:0]    clr_q;
	logic             clr_req_q;
	logic [CNTW-1:0]  walk_q;
	logic             rvld_q;
	logic             done_q;

	req_t             req_q;
	logic [AW-1:0]    addr_q;
	value_t           val_q;
	logic             in_rng_q;

	logic [CNTW-1:0]  zcnt_q;
	sum_t             sum_q;

	value_t           rd_q;
	zero_t            zc_q;
	sum_t             ips_q;
	logic             err_q;

	value_t           mem [DEPTH];
	value_t           mem_rdata_q;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	value_t           mem_wdata;
	logic [AW-1:0]    mem_raddr;

	prec_t            p_eff;
	logic [CNTW-1:0]  size;
	logic [AW-1:0]    idx_addr;
	logic             idx_in_rng;
	logic             accept;
	logic             is_idx;
	value_t           new_val;
	logic             emit;
	value_t           emit_rd;
	logic             emit_err;
	logic             emit_query;
	logic             walk_end;
	logic [SHW-1:0]   shamt;
	sum_t             term;
	logic [AW+INDEX_W-1:0] idx_ext;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// Precision above the store's range saturates to the maximum.
	assign p_eff = (32'(prec_q) > MAX_PRECISION) ? PREC_W'(MAX_PRECISION) : prec_q;
	assign size  = CNTW'(1) << p_eff;

	assign idx_ext    = {{AW{1'b0}}, index};
	assign idx_addr   = idx_ext[AW-1:0];
	assign idx_in_rng = ((CNTW + INDEX_W)'(index) < (CNTW + INDEX_W)'(size));

	assign is_idx   = (req_q == REQ_MAX_UPDATE) || (req_q == REQ_OVERWRITE) ||
		(req_q == REQ_READ);
	assign walk_end = (walk_q == size);

	always_comb begin
		new_val = mem_rdata_q;
		if (req_q == REQ_OVERWRITE) begin
			new_val = val_q;
		end else if (req_q == REQ_MAX_UPDATE && val_q > mem_rdata_q) begin
			new_val = val_q;
		end
	end

	// Shared term unit: 2^-v in fixed point, zero once below the last fraction bit.
	always_comb begin
		shamt = SHW'(SUM_FRAC_BITS) - mem_rdata_q[SHW-1:0];
		if (32'(mem_rdata_q) <= SUM_FRAC_BITS) begin
			term = SUM_W'(1) << shamt;
		end else begin
			term = '0;
		end
	end

	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = addr_q;
		mem_wdata  = new_val;
		mem_raddr  = idx_addr;
		emit       = 1'b0;
		emit_rd    = '0;
		emit_err   = 1'b0;
		emit_query = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				mem_raddr = idx_addr;
			end
			S_IDX: begin
				emit = 1'b1;
				if (is_idx) begin
					if (in_rng_q) begin
						emit_rd = new_val;
						mem_we  = (req_q != REQ_READ);
					end else begin
						emit_err = 1'b1;
					end
				end
			end
			S_QUERY: begin
				mem_raddr = walk_q[AW-1:0];
				if (walk_end && !rvld_q) begin
					emit       = 1'b1;
					emit_query = 1'b1;
				end
			end
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				emit      = clr_req_q && (clr_q == {AW{1'b1}});
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			prec_q    <= PREC_RESET;
			clr_q     <= '0;
			clr_req_q <= 1'b0;
			walk_q    <= '0;
			rvld_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= emit;
			if (cfg_wr_en) begin
				prec_q <= cfg_wr_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_type == REQ_QUERY) begin
							state_q <= S_QUERY;
							walk_q  <= '0;
							rvld_q  <= 1'b0;
						end else if (req_type == REQ_CLEAR) begin
							state_q   <= S_CLEAR;
							clr_q     <= '0;
							clr_req_q <= 1'b1;
						end else begin
							state_q <= S_IDX;
						end
					end
				end
				S_IDX: begin
					state_q <= S_IDLE;
				end
				S_QUERY: begin
					rvld_q <= !walk_end;
					if (!walk_end) begin
						walk_q <= walk_q + CNTW'(1);
					end else if (!rvld_q) begin
						state_q <= S_IDLE;
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == {AW{1'b1}}) begin
						state_q   <= S_IDLE;
						clr_req_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request word, accumulators and result word.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req_type;
			addr_q   <= idx_addr;
			val_q    <= value;
			in_rng_q <= idx_in_rng;
			zcnt_q   <= '0;
			sum_q    <= '0;
		end else if (state_q == S_QUERY && rvld_q) begin
			if (mem_rdata_q == '0) begin
				zcnt_q <= zcnt_q + CNTW'(1);
			end
			sum_q <= sum_q + term;
		end
		if (emit) begin
			rd_q  <= emit_rd;
			err_q <= emit_err;
			zc_q  <= emit_query ? ZERO_W'(zcnt_q) : '0;
			ips_q <= emit_query ? sum_q : '0;
		end
	end

	assign done              = done_q;
	assign read_value        = rd_q;
	assign zero_tally        = zc_q;
	assign inverse_power_sum = ips_q;
	assign index_error       = err_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted word did not raise busy");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q != S_IDLE))
		else $error("result strobe without work in progress");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && err_q) |-> (rd_q == '0 && zc_q == '0 && ips_q == '0))
		else $error("index error result carries data");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QUERY) |-> (walk_q <= size))
		else $error("query walk ran past the active entries");

endmodule

`default_nettype wire
